### sv/ili_pkg.sv
package ili_pkg;

    // input function codes
    localparam logic [1:0] FUNC_APP_A = 2'd0;
    localparam logic [1:0] FUNC_APP_B = 2'd1;
    localparam logic [1:0] FUNC_RUN   = 2'd2;

    // command codes carried through the queue
    localparam logic [1:0] OP_APP_A = 2'd0;
    localparam logic [1:0] OP_APP_B = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;

    localparam int CMD_Q_DEPTH = 4;
    localparam int CMD_Q_AW    = $clog2(CMD_Q_DEPTH);
    localparam int CMD_Q_CW    = $clog2(CMD_Q_DEPTH + 1);

    typedef struct packed {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } t_ent;

    typedef struct packed {
        logic [1:0] op;
        t_ent       ent;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_q_wr;

    typedef struct packed {
        logic empty;
        t_cmd cmd;
    } t_q_rd;

endpackage

### sv/ili_if.sv
interface ili_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [31:0] entry_lo;
    logic signed [31:0] entry_hi;

    modport source (output valid, output func, output entry_lo, output entry_hi, input ready);
    modport sink   (input valid, input func, input entry_lo, input entry_hi, output ready);
endinterface

interface ili_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_lo;
    logic signed [31:0] out_hi;
    logic               is_last;
    logic               empty_res;
    logic               overflow;

    modport source (output valid, output out_lo, output out_hi, output is_last,
                    output empty_res, output overflow, input ready);
    modport sink   (input valid, input out_lo, input out_hi, input is_last,
                    input empty_res, input overflow, output ready);
endinterface

### sv/ili_front.sv
module ili_front (
    ili_in_if.sink         i_in,
    input  logic           i_full,
    output ili_pkg::t_q_wr o_wr
);
    import ili_pkg::*;

    logic       cmd_ok;
    logic [1:0] cmd_op;

    assign i_in.ready = !i_full;

    // map function codes to queue commands; unused code is swallowed
    always_comb begin
        cmd_ok = 1'b1;
        cmd_op = OP_APP_A;
        unique case (i_in.func)
            FUNC_APP_A: cmd_op = OP_APP_A;
            FUNC_APP_B: cmd_op = OP_APP_B;
            FUNC_RUN:   cmd_op = OP_RUN;
            default:    cmd_ok = 1'b0;
        endcase
    end

    assign o_wr.push       = i_in.valid && !i_full && cmd_ok;
    assign o_wr.cmd.op     = cmd_op;
    assign o_wr.cmd.ent.lo = i_in.entry_lo;
    assign o_wr.cmd.ent.hi = i_in.entry_hi;

endmodule

### sv/ili_cmd_fifo.sv
module ili_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ili_pkg::t_q_wr i_wr,
    output logic           o_full,
    input  logic           i_pop,
    output ili_pkg::t_q_rd o_rd
);
    import ili_pkg::*;

    t_cmd                r_mem [CMD_Q_DEPTH];
    logic [CMD_Q_AW-1:0] r_wp, n_wp;
    logic [CMD_Q_AW-1:0] r_rp, n_rp;
    logic [CMD_Q_CW-1:0] r_cnt, n_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_full  = r_cnt == CMD_Q_CW'(CMD_Q_DEPTH);
    assign do_push = i_wr.push && !o_full;
    assign do_pop  = i_pop && (r_cnt != '0);

    assign o_rd.empty = r_cnt == '0;
    assign o_rd.cmd   = r_mem[r_rp];

    always_comb begin
        n_wp  = do_push ? r_wp + CMD_Q_AW'(1) : r_wp;
        n_rp  = do_pop  ? r_rp + CMD_Q_AW'(1) : r_rp;
        n_cnt = r_cnt + CMD_Q_CW'(do_push) - CMD_Q_CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wr.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

### sv/ili_back.sv
module ili_back #(
    parameter int LIST_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ili_pkg::t_q_rd i_rd,
    output logic           o_pop,
    ili_out_if.source      o_out
);
    import ili_pkg::*;

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    t_ent r_mem_a [LIST_DEPTH];
    t_ent r_mem_b [LIST_DEPTH];
    t_ent r_rd_a;
    t_ent r_rd_b;

    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_cnt_a, n_cnt_a;
    logic [CW-1:0]      r_cnt_b, n_cnt_b;
    logic               r_dropped, n_dropped;
    logic [CW-1:0]      r_ia, n_ia;
    logic [CW-1:0]      r_ib, n_ib;
    logic signed [31:0] r_mlo, n_mlo;
    logic signed [31:0] r_mhi, n_mhi;
    logic               r_adv_a, n_adv_a;
    logic               r_found, n_found;
    logic signed [31:0] r_pend_lo, n_pend_lo;
    logic signed [31:0] r_pend_hi, n_pend_hi;
    logic               r_ovf, n_ovf;
    logic               r_out_valid, n_out_valid;
    logic signed [31:0] r_out_lo, n_out_lo;
    logic signed [31:0] r_out_hi, n_out_hi;
    logic               r_out_last, n_out_last;
    logic               r_out_empty, n_out_empty;
    logic               r_out_ovf, n_out_ovf;

    logic out_free;
    logic wr_a;
    logic wr_b;

    assign out_free = !r_out_valid || o_out.ready;
    assign o_pop    = (r_state == S_IDLE) && !i_rd.empty;
    assign wr_a     = o_pop && (i_rd.cmd.op == OP_APP_A) && (r_cnt_a < DEPTH_C);
    assign wr_b     = o_pop && (i_rd.cmd.op == OP_APP_B) && (r_cnt_b < DEPTH_C);

    assign o_out.valid     = r_out_valid;
    assign o_out.out_lo    = r_out_lo;
    assign o_out.out_hi    = r_out_hi;
    assign o_out.is_last   = r_out_last;
    assign o_out.empty_res = r_out_empty;
    assign o_out.overflow  = r_out_ovf;

    // list storage, one write and one registered read per list
    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            r_mem_a[r_cnt_a[IW-1:0]] <= i_rd.cmd.ent;
        end
        if (wr_b) begin
            r_mem_b[r_cnt_b[IW-1:0]] <= i_rd.cmd.ent;
        end
        r_rd_a <= r_mem_a[r_ia[IW-1:0]];
        r_rd_b <= r_mem_b[r_ib[IW-1:0]];
    end

    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_dropped   = r_dropped;
        n_ia        = r_ia;
        n_ib        = r_ib;
        n_mlo       = r_mlo;
        n_mhi       = r_mhi;
        n_adv_a     = r_adv_a;
        n_found     = r_found;
        n_pend_lo   = r_pend_lo;
        n_pend_hi   = r_pend_hi;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_lo    = r_out_lo;
        n_out_hi    = r_out_hi;
        n_out_last  = r_out_last;
        n_out_empty = r_out_empty;
        n_out_ovf   = r_out_ovf;

        unique case (r_state)
            S_IDLE: begin
                if (!i_rd.empty) begin
                    unique case (i_rd.cmd.op)
                        OP_APP_A: begin
                            if (r_cnt_a < DEPTH_C) n_cnt_a = r_cnt_a + CW'(1);
                            else                   n_dropped = 1'b1;
                        end
                        OP_APP_B: begin
                            if (r_cnt_b < DEPTH_C) n_cnt_b = r_cnt_b + CW'(1);
                            else                   n_dropped = 1'b1;
                        end
                        OP_RUN: begin
                            n_ia    = '0;
                            n_ib    = '0;
                            n_found = 1'b0;
                            n_ovf   = r_dropped;
                            n_state = S_RD;
                        end
                        default: ;
                    endcase
                end
            end
            // read data for r_ia / r_ib lands at the end of this cycle
            S_RD: begin
                if ((r_ia < r_cnt_a) && (r_ib < r_cnt_b)) n_state = S_CMP;
                else                                      n_state = S_FIN;
            end
            S_CMP: begin
                n_mlo   = (r_rd_a.lo > r_rd_b.lo) ? r_rd_a.lo : r_rd_b.lo;
                n_mhi   = (r_rd_a.hi < r_rd_b.hi) ? r_rd_a.hi : r_rd_b.hi;
                n_adv_a = r_rd_a.hi < r_rd_b.hi;
                n_state = S_CHK;
            end
            // a found overlap is held back one step so the last one can be flagged
            S_CHK: begin
                if (r_mlo <= r_mhi) begin
                    if (!r_found || out_free) begin
                        if (r_found) begin
                            n_out_valid = 1'b1;
                            n_out_lo    = r_pend_lo;
                            n_out_hi    = r_pend_hi;
                            n_out_last  = 1'b0;
                            n_out_empty = 1'b0;
                            n_out_ovf   = r_ovf;
                        end
                        n_pend_lo = r_mlo;
                        n_pend_hi = r_mhi;
                        n_found   = 1'b1;
                        if (r_adv_a) n_ia = r_ia + CW'(1);
                        else         n_ib = r_ib + CW'(1);
                        n_state = S_RD;
                    end
                end else begin
                    if (r_adv_a) n_ia = r_ia + CW'(1);
                    else         n_ib = r_ib + CW'(1);
                    n_state = S_RD;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_lo    = r_found ? r_pend_lo : 32'sd0;
                    n_out_hi    = r_found ? r_pend_hi : 32'sd0;
                    n_out_last  = 1'b1;
                    n_out_empty = !r_found;
                    n_out_ovf   = r_ovf;
                    n_cnt_a     = '0;
                    n_cnt_b     = '0;
                    n_dropped   = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_dropped   <= 1'b0;
            r_ia        <= '0;
            r_ib        <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_dropped   <= n_dropped;
            r_ia        <= n_ia;
            r_ib        <= n_ib;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mlo       <= n_mlo;
        r_mhi       <= n_mhi;
        r_adv_a     <= n_adv_a;
        r_pend_lo   <= n_pend_lo;
        r_pend_hi   <= n_pend_hi;
        r_ovf       <= n_ovf;
        r_out_lo    <= n_out_lo;
        r_out_hi    <= n_out_hi;
        r_out_last  <= n_out_last;
        r_out_empty <= n_out_empty;
        r_out_ovf   <= n_out_ovf;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= DEPTH_C) && (r_cnt_b <= DEPTH_C))
        else $error("list count past capacity");

    a_ptr_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ((r_ia < r_cnt_a) && (r_ib < r_cnt_b)))
        else $error("walk compares past end of a list");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && out_free) |=>
            ((r_cnt_a == '0) && (r_cnt_b == '0) && !r_dropped && (r_state == S_IDLE)))
        else $error("lists not cleared after run");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |-> r_out_last)
        else $error("empty result not flagged last");

endmodule

### sv/interval_list_intersect_top.sv
// Intersection of two lists of closed signed 32-bit intervals, each list up
// to LIST_DEPTH entries, assumed ascending and disjoint. func 0 appends to
// list A, func 1 to list B, func 2 runs the two-pointer walk and emits each
// overlap in order with is_last on the final one; with no overlap a single
// result with empty_res set is emitted. Appends past capacity are dropped and
// reported in overflow; both lists clear after each run. Input transfers go
// into a four-entry command queue and are taken one per cycle while it has
// room. The executor retires an append from its idle state; a run walks
// at most count_a + count_b - 1 steps, each step being a registered list
// read, a bound compare and an overlap check. The next command starts
// after the run's last result is in the output register.
module interval_list_intersect_top #(
    parameter int LIST_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ili_in_if.sink    i_in,
    ili_out_if.source o_out
);
    import ili_pkg::*;

    t_q_wr q_wr;
    t_q_rd q_rd;
    logic  q_full;
    logic  q_pop;

    ili_front u_front (
        .i_in   (i_in),
        .i_full (q_full),
        .o_wr   (q_wr)
    );

    ili_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rd    (q_rd)
    );

    ili_back #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (q_rd),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

### bench/interval_list_intersect_checker.sv
module interval_list_intersect_checker #(
    parameter int LIST_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ili_in_if    i_in_mon,
    ili_out_if   i_out_mon,
    output int   o_err_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ili_pkg::*;

    typedef struct packed {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic               is_last;
        logic               is_empty;
        logic               ovf;
    } t_overlap;

    logic signed [31:0] a_lo [LIST_DEPTH];
    logic signed [31:0] a_hi [LIST_DEPTH];
    logic signed [31:0] b_lo [LIST_DEPTH];
    logic signed [31:0] b_hi [LIST_DEPTH];
    int                 cnt_a;
    int                 cnt_b;
    logic               drop_seen;

    t_overlap overlap_q [$];

    initial begin
        o_err_count = 0;
        o_pending   = 0;
        cnt_a       = 0;
        cnt_b       = 0;
        drop_seen   = 1'b0;
    end

    // Two-pointer walk; the newest overlap is held back so it can be flagged last.
    function automatic void predict_overlaps();
        int       ia;
        int       ib;
        bit       have_held;
        t_overlap held;
        logic signed [31:0] m_lo;
        logic signed [31:0] m_hi;
        ia        = 0;
        ib        = 0;
        have_held = 1'b0;
        held      = '0;
        while (ia < cnt_a && ib < cnt_b) begin
            m_lo = (a_lo[ia] > b_lo[ib]) ? a_lo[ia] : b_lo[ib];
            m_hi = (a_hi[ia] < b_hi[ib]) ? a_hi[ia] : b_hi[ib];
            if (m_lo <= m_hi) begin
                if (have_held)
                    overlap_q = {overlap_q, held};
                held      = '{lo: m_lo, hi: m_hi, is_last: 1'b0, is_empty: 1'b0,
                              ovf: drop_seen};
                have_held = 1'b1;
            end
            // tie advances B
            if (a_hi[ia] < b_hi[ib])
                ia++;
            else
                ib++;
        end
        if (have_held)
            held.is_last = 1'b1;
        else
            held = '{lo: '0, hi: '0, is_last: 1'b1, is_empty: 1'b1, ovf: drop_seen};
        overlap_q = {overlap_q, held};
        cnt_a     = 0;
        cnt_b     = 0;
        drop_seen = 1'b0;
    endfunction

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            o_err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_overlap exp_r;
        if (!i_rst_n) begin
            cnt_a     = 0;
            cnt_b     = 0;
            drop_seen = 1'b0;
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (overlap_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got lo %0d hi %0d",
                             $time, i_out_mon.out_lo, i_out_mon.out_hi);
                    o_err_count++;
                end else begin
                    exp_r = overlap_q.pop_front();
                    check_field("out_lo", exp_r.lo, i_out_mon.out_lo);
                    check_field("out_hi", exp_r.hi, i_out_mon.out_hi);
                    check_field("is_last", exp_r.is_last, i_out_mon.is_last);
                    check_field("empty_res", exp_r.is_empty, i_out_mon.empty_res);
                    check_field("overflow", exp_r.ovf, i_out_mon.overflow);
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                case (i_in_mon.func)
                    FUNC_APP_A: begin
                        if (cnt_a < LIST_DEPTH) begin
                            a_lo[cnt_a] = i_in_mon.entry_lo;
                            a_hi[cnt_a] = i_in_mon.entry_hi;
                            cnt_a++;
                        end else begin
                            drop_seen = 1'b1;
                        end
                    end
                    FUNC_APP_B: begin
                        if (cnt_b < LIST_DEPTH) begin
                            b_lo[cnt_b] = i_in_mon.entry_lo;
                            b_hi[cnt_b] = i_in_mon.entry_hi;
                            cnt_b++;
                        end else begin
                            drop_seen = 1'b1;
                        end
                    end
                    FUNC_RUN: predict_overlaps();
                    default: ;
                endcase
            end
        end
        o_pending = overlap_q.size();
    end

endmodule

### bench/interval_list_intersect_top_test.sv
module interval_list_intersect_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ili_pkg::*;

    localparam int         LIST_DEPTH   = 16;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam longint     VAL_MIN      = -64'sd2147483648;
    localparam longint     VAL_MAX      = 64'sd2147483647;
    localparam int         RANDOM_ITEMS = 130;
    localparam int         MAX_ENTRIES  = 20;

    logic i_clk;
    logic i_rst_n;
    logic hold_req;
    int   err_count;
    int   pending;
    int   sent_count;
    int   burst_left;

    ili_in_if  in_ch();
    ili_out_if out_ch();

    interval_list_intersect_top #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    interval_list_intersect_checker #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_mon    (in_ch),
        .i_out_mon   (out_ch),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: stretches of always-ready, coin-flip and mostly-stalled
    initial begin
        int  mode;
        int  len;
        bit  hold_done;
        hold_done = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(20, 80);
            repeat (len) begin
                if (hold_req && !hold_done) begin
                    out_ch.ready <= 1'b0;
                    repeat (300) @(posedge i_clk);
                    hold_done = 1'b1;
                end
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= 1'($urandom_range(0, 1));
                    default: out_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input logic [1:0] f, input longint lo, input longint hi);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_ch.valid    <= 1'b1;
        in_ch.func     <= f;
        in_ch.entry_lo <= lo[31:0];
        in_ch.entry_hi <= hi[31:0];
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
        sent_count++;
    endtask

    // ascending, disjoint intervals from base, or arbitrary bounds when malformed
    function automatic void fill_list(input longint base, input int n, input bit wellformed,
                                      output longint lo_v[MAX_ENTRIES],
                                      output longint hi_v[MAX_ENTRIES]);
        longint cur;
        cur = base + $urandom_range(0, 20);
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            lo_v[i] = 0;
            hi_v[i] = 0;
        end
        for (int i = 0; i < n; i++) begin
            if (wellformed) begin
                lo_v[i] = cur + $urandom_range(0, 15);
                hi_v[i] = lo_v[i] + $urandom_range(0, 15);
                cur     = hi_v[i] + 1;
            end else begin
                lo_v[i] = longint'($urandom);
                hi_v[i] = longint'($urandom);
            end
        end
    endfunction

    task automatic send_list_pair();
        longint lo_a [MAX_ENTRIES];
        longint hi_a [MAX_ENTRIES];
        longint lo_b [MAX_ENTRIES];
        longint hi_b [MAX_ENTRIES];
        longint base;
        int     n_a;
        int     n_b;
        int     ka;
        int     kb;
        int     roll;
        bit     wellformed;
        n_a  = $urandom_range(0, 6);
        n_b  = $urandom_range(0, 6);
        roll = $urandom_range(0, 9);
        // now and then overfill one list
        if (roll == 0)
            n_a = $urandom_range(LIST_DEPTH - 1, LIST_DEPTH + 2);
        else if (roll == 1)
            n_b = $urandom_range(LIST_DEPTH - 1, LIST_DEPTH + 2);
        wellformed = ($urandom_range(0, 4) != 0);
        roll       = $urandom_range(0, 9);
        if (roll == 0) begin
            base = VAL_MIN;
        end else if (roll == 1) begin
            base = VAL_MAX - 600;
        end else begin
            base = longint'($signed($urandom));
            if (base > VAL_MAX - 600)
                base -= 600;
        end
        fill_list(base, n_a, wellformed, lo_a, hi_a);
        fill_list(base, n_b, wellformed, lo_b, hi_b);
        ka = 0;
        kb = 0;
        while (ka < n_a || kb < n_b) begin
            if ($urandom_range(0, 11) == 0)
                send_item(FUNC_UNUSED, longint'($urandom), longint'($urandom));
            if (kb >= n_b || (ka < n_a && $urandom_range(0, 1) == 0)) begin
                send_item(FUNC_APP_A, lo_a[ka], hi_a[ka]);
                ka++;
            end else begin
                send_item(FUNC_APP_B, lo_b[kb], hi_b[kb]);
                kb++;
            end
        end
        send_item(FUNC_RUN, longint'($urandom), longint'($urandom));
    endtask

    initial begin
        int directed_count;
        i_rst_n        <= 1'b0;
        hold_req        = 1'b0;
        sent_count      = 0;
        burst_left      = 0;
        in_ch.valid    <= 1'b0;
        in_ch.func     <= FUNC_APP_A;
        in_ch.entry_lo <= '0;
        in_ch.entry_hi <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // both lists empty
        send_item(FUNC_RUN, 0, 0);
        // full-range A against extreme points in B
        send_item(FUNC_APP_A, VAL_MIN, VAL_MAX);
        send_item(FUNC_APP_B, VAL_MIN, VAL_MIN);
        send_item(FUNC_APP_B, VAL_MAX, VAL_MAX);
        send_item(FUNC_RUN, VAL_MAX, VAL_MIN);
        // equal highs, then B ahead; unused code in between
        send_item(FUNC_APP_A, 0, 10);
        send_item(FUNC_APP_A, 20, 30);
        send_item(FUNC_APP_B, 5, 10);
        send_item(FUNC_UNUSED, VAL_MIN, VAL_MAX);
        send_item(FUNC_APP_B, 12, 25);
        send_item(FUNC_RUN, 0, 0);
        // one list empty
        send_item(FUNC_APP_A, 1, 2);
        send_item(FUNC_RUN, 0, 0);
        // reversed interval, no overlap
        send_item(FUNC_APP_A, 10, 5);
        send_item(FUNC_APP_B, 4, 12);
        send_item(FUNC_RUN, 0, 0);
        // adjacent but disjoint points
        send_item(FUNC_APP_B, 4, 4);
        send_item(FUNC_APP_A, 3, 3);
        send_item(FUNC_RUN, 0, 0);
        directed_count = sent_count;

        hold_req = 1'b1;
        while (sent_count < directed_count + RANDOM_ITEMS)
            send_list_pair();
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
